FILE: src/vku_pkg.sv
`default_nettype none

package vku_pkg;

    // Value width of every stored and reported Q16.16 quantity.
    localparam int VW = 32;
    // Width of an unsigned Q1.16 gain or rate that can reach 1.0.
    localparam int GW = 17;
    // Width of the saturation input, wide enough for every sum in the update.
    localparam int SW = 54;
    // Shared multiplier operand and product widths.
    localparam int MAW = 18;
    localparam int MBW = 35;
    localparam int MPW = MAW + MBW;
    // Divider operand width: magnitudes of w+v and w+v+noise.
    localparam int DW = 34;

    localparam logic [GW-1:0] GAIN_ONE = 17'd65536;

    // Command codes.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_TRIAL = 1'b1;

    typedef struct packed {
        logic                 command;
        logic [5:0]           choice;
        logic signed [VW-1:0] outcome;
        logic                 outcome_present;
        logic [GW-1:0]        volatility_rate;
        logic signed [VW-1:0] load_prediction;
        logic signed [VW-1:0] load_volatility;
        logic signed [VW-1:0] load_uncertainty;
    } in_t;

    typedef struct packed {
        logic signed [VW-1:0] prior_prediction;
        logic signed [VW-1:0] prior_volatility;
        logic signed [VW-1:0] prior_uncertainty;
        logic signed [VW-1:0] prediction_error;
        logic [GW-1:0]        learning_rate;
        logic signed [VW-1:0] volatility_error;
        logic                 updated;
    } out_t;

    // Request to the gain divider: both magnitudes are nonzero.
    typedef struct packed {
        logic          start;
        logic [DW-1:0] num;
        logic [DW-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic          done;
        logic [GW-1:0] gain;
    } div_rsp_t;

    // Clamp a wide signed value into the signed value range.
    function automatic logic signed [VW-1:0] sat_val(input logic signed [SW-1:0] x);
        logic signed [VW-1:0] r;
        if ((&x[SW-1:VW-1]) || !(|x[SW-1:VW-1])) begin
            r = x[VW-1:0];
        end else if (x[SW-1]) begin
            r = {1'b1, {(VW-1){1'b0}}};
        end else begin
            r = {1'b0, {(VW-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: src/vku_ram.sv
`default_nettype none

module vku_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                  aclk,
    input  wire logic                  we,
    input  wire logic [AW-1:0]         waddr,
    input  wire logic [WIDTH-1:0]      wdata,
    input  wire logic [AW-1:0]         raddr,
    output logic      [WIDTH-1:0]      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: src/vku_mul.sv
`default_nettype none

module vku_mul
    import vku_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic signed [MAW-1:0]  a,
    input  wire logic signed [MBW-1:0]  b,
    output logic      signed [MPW-1:0]  prod
);

    // Shared signed multiplier with its product registered.
    always_ff @(posedge aclk) begin
        prod <= MPW'(a) * MPW'(b);
    end

endmodule

`default_nettype wire

FILE: src/vku_div.sv
`default_nettype none

module vku_div
    import vku_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);
    typedef enum logic {
        D_IDLE,
        D_RUN
    } dstate_t;

    localparam int QB = GW - 1;

    dstate_t         state_reg;
    logic            done_reg;
    logic [GW-1:0]   gain_reg;
    logic [DW:0]     r_reg;
    logic [DW-1:0]   ud_reg;
    logic [QB-1:0]   q_reg;
    logic [4:0]      cnt_reg;

    logic            ge;
    logic [DW:0]     rsub;
    logic [GW-1:0]   qf;

    // One quotient bit per cycle by restoring subtraction.
    always_comb begin
        ge   = (r_reg >= {1'b0, ud_reg});
        rsub = ge ? (r_reg - {1'b0, ud_reg}) : r_reg;
        qf   = {q_reg, ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE: begin
                    if (req.start) begin
                        ud_reg <= req.den;
                        // A quotient of two or more clamps to one at once.
                        if ({1'b0, req.num} >= {req.den, 1'b0}) begin
                            gain_reg <= GAIN_ONE;
                            done_reg <= 1'b1;
                        end else begin
                            r_reg     <= {1'b0, req.num};
                            q_reg     <= '0;
                            cnt_reg   <= 5'(QB);
                            state_reg <= D_RUN;
                        end
                    end
                end
                D_RUN: begin
                    r_reg   <= {rsub[DW-1:0], 1'b0};
                    q_reg   <= qf[QB-1:0];
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0) begin
                        gain_reg  <= (qf > GAIN_ONE) ? GAIN_ONE : qf;
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.gain = gain_reg;

endmodule

`default_nettype wire

FILE: src/volatile_kalman_update.sv
`default_nettype none

// Channel   Direction  Handshake          Word
// s_        in         s_valid / s_ready  in_t: command, choice, outcome, rates, load values
// m_        out        m_valid / m_ready  out_t: prior values, errors, gain, updated
//
// A load goes from the accept straight to the output step, an absent-outcome trial
// reads its entry first, and a trial with an outcome also runs the 17-step gain
// divider, skipped when the gain is zero and cut short when it clamps to one at once,
// and six passes through the one shared 18x35 multiplier. s_ready is high only while the sequencer
// is idle; a finished result waits in the output register, the next word is accepted
// meanwhile, and a second finished result holds the sequencer until the first is
// taken. Reset is synchronous, active low; the tables are not cleared.
module volatile_kalman_update
    import vku_pkg::*;
#(
    parameter int CHOICES = 64
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);
    localparam int AW = (CHOICES > 1) ? $clog2(CHOICES) : 1;
    localparam int RW = 4 * VW;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_CAPTURE,
        S_GAIN,
        S_DIVIDE,
        S_MKP,
        S_MKW,
        S_MKC,
        S_MSQL,
        S_MSQH,
        S_MVE,
        S_MRV,
        S_WB,
        S_OUT
    } state_t;

    state_t               state_reg;
    in_t                  req_reg;
    logic signed [VW-1:0] p_reg, v_reg, w_reg, s_reg;
    logic signed [VW-1:0] perr_reg, np_reg, nw_reg, verr_reg;
    logic signed [VW:0]   wv_reg, wcov_reg;
    logic signed [DW-1:0] den_reg;
    logic [GW-1:0]        k_reg;
    logic [VW-1:0]        sqlo_reg;
    logic signed [35:0]   t_reg;
    out_t                 res_reg;
    logic                 m_valid_reg;
    out_t                 m_data_reg;

    logic                 s_fire;
    logic                 in_range;
    logic                 we;
    logic [AW-1:0]        waddr, raddr;
    logic [RW-1:0]        wdata, rdata;
    logic signed [MAW-1:0] mul_a;
    logic signed [MBW-1:0] mul_b;
    logic signed [MPW-1:0] prod;
    logic signed [MPW-1:0] prod_sh;
    logic [GW-1:0]        omk;
    logic [GW-1:0]        rate_c;
    logic signed [VW:0]   dp;
    logic [VW:0]          mag;
    logic signed [DW-1:0] numx;
    logic                 trivial;
    div_req_t             dreq;
    div_rsp_t             drsp;
    logic signed [VW-1:0] nv;
    out_t                 load_res;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign in_range = ({26'd0, s_data.choice} < 32'(CHOICES));

    // Entry storage: noise, uncertainty, volatility, prediction in one row.
    assign raddr = (state_reg == S_IDLE) ? AW'(s_data.choice) : AW'(req_reg.choice);
    always_comb begin
        we    = 1'b0;
        waddr = AW'(req_reg.choice);
        wdata = {s_reg, nw_reg, nv, np_reg};
        if (state_reg == S_IDLE) begin
            waddr = AW'(s_data.choice);
            wdata = {s_data.load_uncertainty, s_data.load_uncertainty,
                     s_data.load_volatility, s_data.load_prediction};
            we    = s_fire && in_range && (s_data.command == CMD_LOAD);
        end else if (state_reg == S_WB) begin
            we = 1'b1;
        end
    end

    vku_ram #(
        .WIDTH (RW),
        .DEPTH (CHOICES)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Result of a load: the loaded values echoed, every other field zero.
    always_comb begin
        load_res                   = '0;
        load_res.prior_prediction  = s_data.load_prediction;
        load_res.prior_volatility  = s_data.load_volatility;
        load_res.prior_uncertainty = s_data.load_uncertainty;
    end

    // Helper terms around the shared multiplier.
    always_comb begin
        omk     = GAIN_ONE - k_reg;
        rate_c  = (req_reg.volatility_rate > GAIN_ONE) ? GAIN_ONE : req_reg.volatility_rate;
        dp      = (VW+1)'(np_reg) - (VW+1)'(p_reg);
        mag     = dp[VW] ? $unsigned(-dp) : $unsigned(dp);
        prod_sh = prod >>> 16;
        nv      = sat_val(SW'(v_reg) + SW'(prod_sh));
    end

    // Operand selection per sequencer step.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MKP: begin
                mul_a = {1'b0, k_reg};
                mul_b = MBW'(perr_reg);
            end
            S_MKW: begin
                mul_a = {1'b0, omk};
                mul_b = MBW'(wv_reg);
            end
            S_MKC: begin
                mul_a = {1'b0, omk};
                mul_b = MBW'(w_reg);
            end
            S_MSQL: begin
                mul_a = {2'b00, mag[15:0]};
                mul_b = {2'b00, mag};
            end
            S_MSQH: begin
                mul_a = {1'b0, mag[VW:16]};
                mul_b = {2'b00, mag};
            end
            S_MRV: begin
                mul_a = {1'b0, rate_c};
                mul_b = MBW'(verr_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    vku_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // Gain divider request: zero or opposite-sign operands give gain zero.
    always_comb begin
        numx       = DW'(wv_reg);
        trivial    = (wv_reg == '0) || (den_reg == '0) || (wv_reg[VW] != den_reg[DW-1]);
        dreq.start = (state_reg == S_GAIN) && !trivial;
        dreq.num   = numx[DW-1] ? DW'(-numx) : DW'(numx);
        dreq.den   = den_reg[DW-1] ? DW'(-den_reg) : DW'(den_reg);
    end

    vku_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .rsp     (drsp)
    );

    // Sequencer, datapath registers and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // The output register takes a finished word or empties on acceptance.
            if ((state_reg == S_OUT) && (!m_valid_reg || m_ready)) begin
                m_data_reg  <= res_reg;
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        req_reg <= s_data;
                        if (!in_range) begin
                            res_reg   <= '0;
                            state_reg <= S_OUT;
                        end else if (s_data.command == CMD_LOAD) begin
                            res_reg   <= load_res;
                            state_reg <= S_OUT;
                        end else begin
                            res_reg   <= '0;
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    p_reg <= rdata[VW-1:0];
                    v_reg <= rdata[2*VW-1:VW];
                    w_reg <= rdata[3*VW-1:2*VW];
                    s_reg <= rdata[4*VW-1:3*VW];
                    res_reg.prior_prediction  <= rdata[VW-1:0];
                    res_reg.prior_volatility  <= rdata[2*VW-1:VW];
                    res_reg.prior_uncertainty <= rdata[3*VW-1:2*VW];
                    state_reg <= req_reg.outcome_present ? S_CAPTURE : S_OUT;
                end
                S_CAPTURE: begin
                    perr_reg  <= sat_val(SW'(req_reg.outcome) - SW'(p_reg));
                    wv_reg    <= (VW+1)'(w_reg) + (VW+1)'(v_reg);
                    den_reg   <= DW'(w_reg) + DW'(v_reg) + DW'(s_reg);
                    state_reg <= S_GAIN;
                end
                S_GAIN: begin
                    if (trivial) begin
                        k_reg     <= '0;
                        state_reg <= S_MKP;
                    end else begin
                        state_reg <= S_DIVIDE;
                    end
                end
                S_DIVIDE: begin
                    if (drsp.done) begin
                        k_reg     <= drsp.gain;
                        state_reg <= S_MKP;
                    end
                end
                S_MKP: begin
                    state_reg <= S_MKW;
                end
                S_MKW: begin
                    np_reg    <= sat_val(SW'(p_reg) + SW'(prod_sh));
                    state_reg <= S_MKC;
                end
                S_MKC: begin
                    nw_reg    <= sat_val(SW'(prod_sh));
                    state_reg <= S_MSQL;
                end
                S_MSQL: begin
                    wcov_reg  <= (VW+1)'(prod_sh);
                    state_reg <= S_MSQH;
                end
                S_MSQH: begin
                    sqlo_reg  <= VW'(prod_sh);
                    t_reg     <= 36'(nw_reg) + 36'(w_reg) - (36'(wcov_reg) <<< 1)
                                 - 36'(v_reg);
                    state_reg <= S_MVE;
                end
                S_MVE: begin
                    verr_reg  <= sat_val(SW'(prod) + SW'($signed({1'b0, sqlo_reg}))
                                         + SW'(t_reg));
                    state_reg <= S_MRV;
                end
                S_MRV: begin
                    state_reg <= S_WB;
                end
                S_WB: begin
                    res_reg.prediction_error <= perr_reg;
                    res_reg.learning_rate    <= k_reg;
                    res_reg.volatility_error <= verr_reg;
                    res_reg.updated          <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

FILE: test/volatile_kalman_update_test.sv
`timescale 1ns / 100ps

module volatile_kalman_update_test
    import vku_pkg::*;
;

    localparam int WATCHDOG_LIMIT = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    volatile_kalman_update dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #5 aclk = ~aclk;

    // Filter state as the predictor sees it.
    logic signed [VW-1:0] pred_tab [64];
    logic signed [VW-1:0] vol_tab [64];
    logic signed [VW-1:0] unc_tab [64];
    logic signed [VW-1:0] noise_tab [64];
    bit loaded [64];

    in_t  pending_words [$];
    out_t expected_results [$];
    int   error_count = 0;
    bit   stimulus_done = 1'b0;
    bit   sender_hold = 1'b0;
    int   receiver_hold = 0;

    function automatic logic signed [VW-1:0] clamp_value(input longint x);
        if (x > 64'sd2147483647) return 32'sh7fffffff;
        if (x < -64'sd2147483648) return 32'sh80000000;
        return x[VW-1:0];
    endfunction

    // Arithmetic shift is floor division by 65536.
    function automatic longint floor_q16(input longint x);
        return x >>> 16;
    endfunction

    // Kalman gain: truncated quotient, clamped to one, zero on a zero operand or sign mismatch.
    function automatic longint kalman_gain(input longint num, input longint den);
        longint un, ud, q;
        if (den == 0 || num == 0) return 0;
        if ((num < 0) != (den < 0)) return 0;
        un = num < 0 ? -num : num;
        ud = den < 0 ? -den : den;
        q = (un << 16) / ud;
        return q > 65536 ? 65536 : q;
    endfunction

    // Apply one word to the filter state and return the result it causes.
    function automatic out_t filter_step(input in_t w);
        out_t r;
        longint p, v, u, o, s, rate, perr, wv, k, np, nw, wcov, mag, sq, verr;
        r = '0;
        if (w.command == CMD_LOAD) begin
            pred_tab[w.choice] = w.load_prediction;
            vol_tab[w.choice] = w.load_volatility;
            unc_tab[w.choice] = w.load_uncertainty;
            noise_tab[w.choice] = w.load_uncertainty;
            r.prior_prediction = w.load_prediction;
            r.prior_volatility = w.load_volatility;
            r.prior_uncertainty = w.load_uncertainty;
            return r;
        end
        p = pred_tab[w.choice];
        v = vol_tab[w.choice];
        u = unc_tab[w.choice];
        r.prior_prediction = pred_tab[w.choice];
        r.prior_volatility = vol_tab[w.choice];
        r.prior_uncertainty = unc_tab[w.choice];
        if (!w.outcome_present) return r;
        o = w.outcome;
        s = noise_tab[w.choice];
        rate = w.volatility_rate > 65536 ? 65536 : w.volatility_rate;
        perr = clamp_value(o - p);
        wv = u + v;
        k = kalman_gain(wv, wv + s);
        np = clamp_value(p + floor_q16(k * perr));
        nw = clamp_value(floor_q16((65536 - k) * wv));
        wcov = floor_q16((65536 - k) * u);
        mag = np > p ? np - p : p - np;
        // The square can pass 2^63, so it is formed unsigned.
        sq = longint'(($unsigned(mag) * $unsigned(mag)) >> 16);
        verr = clamp_value(sq + nw + u - 2 * wcov - v);
        pred_tab[w.choice] = VW'(np);
        unc_tab[w.choice] = VW'(nw);
        vol_tab[w.choice] = clamp_value(v + floor_q16(rate * verr));
        r.prediction_error = VW'(perr);
        r.learning_rate = GW'(k);
        r.volatility_error = VW'(verr);
        r.updated = 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
        error_count++;
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 4) << 16;
            3: return $urandom_range(0, 262143) - 131072;
            default: return $urandom();
        endcase
    endfunction

    function automatic in_t make_load(input int ch, input logic [31:0] p,
                                      input logic [31:0] v, input logic [31:0] u);
        in_t w;
        w = '0;
        w.command = CMD_LOAD;
        w.choice = 6'(ch);
        w.outcome = $urandom();
        w.volatility_rate = GW'($urandom());
        w.outcome_present = 1'($urandom());
        w.load_prediction = p;
        w.load_volatility = v;
        w.load_uncertainty = u;
        return w;
    endfunction

    function automatic in_t make_trial(input int ch, input logic [31:0] o,
                                       input bit present, input logic [16:0] rate);
        in_t w;
        w = '0;
        w.command = CMD_TRIAL;
        w.choice = 6'(ch);
        w.outcome = o;
        w.outcome_present = present;
        w.volatility_rate = rate;
        w.load_prediction = $urandom();
        w.load_volatility = $urandom();
        w.load_uncertainty = $urandom();
        return w;
    endfunction

    // Driver: one word at a time after a random gap.
    int send_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_results.push_back(filter_step(s_data));
                send_gap = $urandom_range(0, 11);
                if ($urandom_range(0, 3) == 0) send_gap = 0;
            end
            if (!(s_valid && !s_ready)) begin
                if (send_gap > 0 || sender_hold || pending_words.size() == 0) begin
                    if (send_gap > 0) send_gap--;
                    s_valid <= 1'b0;
                end else begin
                    s_data <= pending_words.pop_front();
                    s_valid <= 1'b1;
                end
            end
        end
    end

    // Monitor and receiver stall.
    int recv_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("unexpected result word at %0t", $realtime);
                    error_count++;
                end else begin
                    out_t e;
                    e = expected_results.pop_front();
                    if (m_data.prior_prediction !== e.prior_prediction)
                        report_mismatch("prior_prediction", m_data.prior_prediction,
                                        e.prior_prediction);
                    if (m_data.prior_volatility !== e.prior_volatility)
                        report_mismatch("prior_volatility", m_data.prior_volatility,
                                        e.prior_volatility);
                    if (m_data.prior_uncertainty !== e.prior_uncertainty)
                        report_mismatch("prior_uncertainty", m_data.prior_uncertainty,
                                        e.prior_uncertainty);
                    if (m_data.prediction_error !== e.prediction_error)
                        report_mismatch("prediction_error", m_data.prediction_error,
                                        e.prediction_error);
                    if (m_data.learning_rate !== e.learning_rate)
                        report_mismatch("learning_rate", 32'(m_data.learning_rate),
                                        32'(e.learning_rate));
                    if (m_data.volatility_error !== e.volatility_error)
                        report_mismatch("volatility_error", m_data.volatility_error,
                                        e.volatility_error);
                    if (m_data.updated !== e.updated)
                        report_mismatch("updated", 32'(m_data.updated), 32'(e.updated));
                end
                recv_gap = $urandom_range(0, 11);
                if ($urandom_range(0, 3) == 0) recv_gap = 0;
            end
            if (receiver_hold > 0) begin
                receiver_hold--;
                m_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any accepted word.
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Stimulus source.
    initial begin
        int ch;
        logic [31:0] ext [4];
        ext = '{32'h7fffffff, 32'h80000000, 32'h00000000, 32'hffffffff};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: extreme loads, then trials covering each special case.
        pending_words.push_back(make_load(0, 32'h00010000, 32'h00008000, 32'h00010000));
        pending_words.push_back(make_load(63, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
        pending_words.push_back(make_load(1, 32'h80000000, 32'h80000000, 32'h80000000));
        pending_words.push_back(make_load(2, 0, 0, 0));
        pending_words.push_back(make_load(3, 32'h00010000, 32'hffff0000, 32'h00010000));
        pending_words.push_back(make_load(4, 0, 32'h00020000, 32'hfffe0000));
        pending_words.push_back(make_trial(0, 32'h00030000, 1, 17'd6554));
        pending_words.push_back(make_trial(0, 32'h00030000, 0, 17'd6554));
        pending_words.push_back(make_trial(63, 32'h80000000, 1, 17'd65536));
        pending_words.push_back(make_trial(1, 32'h7fffffff, 1, 17'h1ffff));
        pending_words.push_back(make_trial(2, 32'h00050000, 1, 17'd100));
        pending_words.push_back(make_trial(3, 32'hfffb0000, 1, 17'd0));
        pending_words.push_back(make_trial(4, 32'h00010000, 1, 17'd65537));
        pending_words.push_back(make_trial(63, 32'h7fffffff, 1, 17'd32768));
        pending_words.push_back(make_trial(1, 32'h80000000, 0, 17'd0));
        foreach (ext[i]) pending_words.push_back(make_trial(0, ext[i], 1, 17'd65536));
        for (int i = 0; i < 64; i++) loaded[i] = (i <= 4 || i == 63);

        // Random part in bursts; one burst runs under a long receiver hold,
        // and the sender drains fully between bursts now and then.
        for (int burst = 0; burst < 25; burst++) begin
            for (int n = 0; n < 50; n++) begin
                ch = $urandom_range(0, 63);
                if (!loaded[ch] || $urandom_range(0, 9) == 0) begin
                    pending_words.push_back(make_load(ch, rand_value(), rand_value(),
                                                      rand_value()));
                    loaded[ch] = 1'b1;
                end else begin
                    pending_words.push_back(make_trial(ch, rand_value(),
                                                       $urandom_range(0, 7) != 0,
                                                       GW'($urandom_range(0, 131071))));
                end
            end
            if (burst == 5) receiver_hold = 600;
            wait (pending_words.size() == 0);
            if (burst % 4 == 0) begin
                sender_hold = 1'b1;
                wait (!s_valid && expected_results.size() == 0);
                sender_hold = 1'b0;
            end
        end

        wait (pending_words.size() == 0 && !s_valid);
        wait (expected_results.size() == 0);
        repeat (50) @(posedge aclk);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
